>>> rtl/assert_macros.svh
// Assertion macros shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising clock edge, skipped while reset is high.
`define HRLP_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Property checked at every rising clock edge, reset included.
`define HRLP_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) (prop)) else $error(msg);

`endif

>>> rtl/hrlp_pkg.sv
// Types and constants for the HTTP response length parser.
`timescale 1ns / 1ps
`default_nettype none

package hrlp_pkg;

   typedef enum logic [3:0] {
      PH_SEEK_SPACE = 4'd0,
      PH_STATUS1    = 4'd1,
      PH_STATUS2    = 4'd2,
      PH_STATUS3    = 4'd3,
      PH_SKIP_LINE  = 4'd4,
      PH_LINE_START = 4'd5,
      PH_MATCH      = 4'd6,
      PH_SEPARATOR  = 4'd7,
      PH_DIGITS     = 4'd8,
      PH_VALUE_LF   = 4'd9,
      PH_END_LF     = 4'd10,
      PH_DONE       = 4'd11
   } phase_type;

   localparam logic [3:0] NAME_LEN = 4'd14;

   localparam logic [7:0] CH_TWO   = 8'h32;  // '2'
   localparam logic [7:0] CH_ZERO  = 8'h30;  // '0'
   localparam logic [7:0] CH_NINE  = 8'h39;  // '9'
   localparam logic [7:0] CH_COLON = 8'h3A;  // ':'
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_TAB   = 8'h09;

   // "Content-Length", one character per index
   function automatic logic [7:0] name_char(input logic [3:0] idx);
      logic [7:0] ch;
      case (idx)
         4'd0:    ch = 8'h43;  // C
         4'd1:    ch = 8'h6F;  // o
         4'd2:    ch = 8'h6E;  // n
         4'd3:    ch = 8'h74;  // t
         4'd4:    ch = 8'h65;  // e
         4'd5:    ch = 8'h6E;  // n
         4'd6:    ch = 8'h74;  // t
         4'd7:    ch = 8'h2D;  // -
         4'd8:    ch = 8'h4C;  // L
         4'd9:    ch = 8'h65;  // e
         4'd10:   ch = 8'h6E;  // n
         4'd11:   ch = 8'h67;  // g
         4'd12:   ch = 8'h74;  // t
         4'd13:   ch = 8'h68;  // h
         default: ch = 8'h00;
      endcase
      return ch;
   endfunction

endpackage

`default_nettype wire

>>> rtl/http_response_length_parser.sv
// HTTP response length parser: status check and Content-Length extraction.
`timescale 1ns / 1ps
`default_nettype none
//
// Usage
//   req_*: one response byte per word. req_tuser[0] set restarts the parser
//   on that byte (first byte of a new response).
//   rsp_*: one word per response, sent when the status code is not 200
//   (on the first bad status byte) or on the byte after the blank line's CR.
//   Bytes after the result are dropped until the next restart.
// Pipeline / throughput
//   A byte is held in the input register, is decoded against the
//   parser state, and its result lands in the output register, which
//   drives rsp_tvalid. One byte per cycle sustained while no result is
//   held back by rsp_tready low; the per-byte step (phase decode plus a
//   LENGTH_BITS+4 bit multiply-by-ten add with saturation) fits between those two registers.
// Reset
//   Synchronous, active high. Parser goes to status-space search with the
//   length cleared; both pipeline registers empty.
// Backpressure
//   While rsp_tready is low with a result held, the input register keeps its
//   byte and req_tready drops once it is full; nothing is lost or repeated.
//
module http_response_length_parser #(
   parameter int LENGTH_BITS = 32
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // request stream
   input  wire logic        req_tvalid,
   output      logic        req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] rx_byte
   input  wire logic [0:0]  req_tuser,   // [0] first
   // result stream
   output      logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   output      logic [31:0] rsp_tdata,   // [31:0] content_length
   output      logic [2:0]  rsp_tuser    // [0] status_ok, [1] length_found, [2] malformed
);

   import hrlp_pkg::*;

   localparam int SUM_W = LENGTH_BITS + 4;

   // input register
   logic                   in_valid_ff, in_valid_in;
   logic [7:0]             in_byte_ff;
   logic                   in_first_ff;

   // parser state
   phase_type              phase_ff, phase_in;
   logic [3:0]             match_ff, match_in;
   logic [LENGTH_BITS-1:0] accum_ff, accum_in;
   logic                   seen_ff, seen_in;
   logic                   bad_ff, bad_in;
   logic                   after_cr_ff, after_cr_in;

   // output register
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [31:0]            rsp_data_ff;
   logic [2:0]             rsp_user_ff;

   logic                   slot_free, advance, req_accept;
   logic                   emit;
   logic [31:0]            emit_data;
   logic [2:0]             emit_user;

   // effective state after an optional restart
   phase_type              cur_phase;
   logic [3:0]             cur_match;
   logic [LENGTH_BITS-1:0] cur_accum;
   logic                   cur_seen, cur_bad, cur_after_cr;

   // digit accumulate
   logic                   is_digit, is_sep;
   logic [SUM_W-1:0]       accum_ext, accum_sum;
   logic                   sum_over;
   logic [LENGTH_BITS-1:0] digit_accum;
   logic                   digit_bad;

   assign slot_free  = !rsp_valid_ff || rsp_tready;
   assign advance    = in_valid_ff && slot_free;
   assign req_tready = !in_valid_ff || slot_free;
   assign req_accept = req_tvalid && req_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   always_comb begin
      if (in_first_ff) begin
         cur_phase    = PH_SEEK_SPACE;
         cur_match    = '0;
         cur_accum    = '0;
         cur_seen     = 1'b0;
         cur_bad      = 1'b0;
         cur_after_cr = 1'b0;
      end else begin
         cur_phase    = phase_ff;
         cur_match    = match_ff;
         cur_accum    = accum_ff;
         cur_seen     = seen_ff;
         cur_bad      = bad_ff;
         cur_after_cr = after_cr_ff;
      end
   end

   // value*10 + digit, saturating; low nibble of an ASCII digit is its value
   assign is_digit  = (in_byte_ff inside {[CH_ZERO:CH_NINE]});
   assign is_sep    = (in_byte_ff inside {CH_SPACE, CH_COLON, [CH_TAB:CH_CR]});
   assign accum_ext = SUM_W'(cur_accum);
   assign accum_sum = (accum_ext << 3) + (accum_ext << 1) + SUM_W'(in_byte_ff[3:0]);
   assign sum_over  = |accum_sum[SUM_W-1:LENGTH_BITS];

   always_comb begin
      if (!is_digit) begin
         digit_accum = cur_accum;
         digit_bad   = 1'b1;
      end else if (sum_over) begin
         digit_accum = '1;
         digit_bad   = 1'b1;
      end else begin
         digit_accum = accum_sum[LENGTH_BITS-1:0];
         digit_bad   = cur_bad;
      end
   end

   // per-byte step
   always_comb begin
      phase_in    = cur_phase;
      match_in    = cur_match;
      accum_in    = cur_accum;
      seen_in     = cur_seen;
      bad_in      = cur_bad;
      after_cr_in = cur_after_cr;
      emit        = 1'b0;
      emit_data   = '0;
      emit_user   = '0;
      case (cur_phase)
         PH_SEEK_SPACE: begin
            if (in_byte_ff == CH_SPACE) phase_in = PH_STATUS1;
         end
         PH_STATUS1, PH_STATUS2, PH_STATUS3: begin
            if (in_byte_ff != ((cur_phase == PH_STATUS1) ? CH_TWO : CH_ZERO)) begin
               emit     = 1'b1;  // bad status: all-zero result
               phase_in = PH_DONE;
            end else if (cur_phase == PH_STATUS3) begin
               after_cr_in = 1'b0;
               phase_in    = PH_SKIP_LINE;
            end else if (cur_phase == PH_STATUS1) begin
               phase_in = PH_STATUS2;
            end else begin
               phase_in = PH_STATUS3;
            end
         end
         PH_SKIP_LINE: begin
            if (cur_after_cr) begin
               after_cr_in = 1'b0;
               if (in_byte_ff == CH_LF) phase_in = PH_LINE_START;
            end else if (in_byte_ff == CH_CR) begin
               after_cr_in = 1'b1;
            end
         end
         PH_LINE_START: begin
            if (in_byte_ff == CH_CR) begin
               phase_in = PH_END_LF;
            end else if (in_byte_ff == name_char(4'd0)) begin
               match_in = 4'd1;
               phase_in = PH_MATCH;
            end else begin
               after_cr_in = 1'b0;
               phase_in    = PH_SKIP_LINE;
            end
         end
         PH_MATCH: begin
            if (cur_match < NAME_LEN && in_byte_ff == name_char(cur_match)) begin
               match_in = cur_match + 4'd1;
               if (cur_match + 4'd1 == NAME_LEN) begin
                  seen_in  = 1'b1;
                  accum_in = '0;
                  phase_in = PH_SEPARATOR;
               end
            end else begin
               after_cr_in = 1'b0;
               phase_in    = PH_SKIP_LINE;
            end
         end
         PH_SEPARATOR: begin
            if (!is_sep) begin
               accum_in = digit_accum;
               bad_in   = digit_bad;
               phase_in = PH_DIGITS;
            end
         end
         PH_DIGITS: begin
            if (in_byte_ff == CH_CR) begin
               phase_in = PH_VALUE_LF;
            end else begin
               accum_in = digit_accum;
               bad_in   = digit_bad;
            end
         end
         PH_VALUE_LF: begin
            phase_in = PH_LINE_START;
         end
         PH_END_LF: begin
            emit      = 1'b1;
            emit_data = 32'(cur_accum);
            emit_user = {cur_bad, cur_seen, 1'b1};
            phase_in  = PH_DONE;
         end
         default: begin
            phase_in = PH_DONE;
         end
      endcase
   end

   always_comb begin
      if (req_accept)   in_valid_in = 1'b1;
      else if (advance) in_valid_in = 1'b0;
      else              in_valid_in = in_valid_ff;

      if (advance && emit)             rsp_valid_in = 1'b1;
      else if (rsp_valid_ff && rsp_tready) rsp_valid_in = 1'b0;
      else                             rsp_valid_in = rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         phase_ff     <= PH_SEEK_SPACE;
         match_ff     <= '0;
         accum_ff     <= '0;
         seen_ff      <= 1'b0;
         bad_ff       <= 1'b0;
         after_cr_ff  <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            phase_ff    <= phase_in;
            match_ff    <= match_in;
            accum_ff    <= accum_in;
            seen_ff     <= seen_in;
            bad_ff      <= bad_in;
            after_cr_ff <= after_cr_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_byte_ff  <= req_tdata;
         in_first_ff <= req_tuser[0];
      end
      if (advance && emit) begin
         rsp_data_ff <= emit_data;
         rsp_user_ff <= emit_user;
      end
   end

`include "assert_macros.svh"

   `HRLP_ASSERT(a_emit_slot, (advance && emit) |-> slot_free,
      "result loaded into a busy output register")
   `HRLP_ASSERT(a_emit_done, (advance && emit) |=> (phase_ff == PH_DONE),
      "parser not finished after result")
   `HRLP_ASSERT(a_bad_status_zero, (rsp_valid_ff && !rsp_user_ff[0]) |->
      (rsp_user_ff == 3'b000 && rsp_data_ff == 32'd0), "bad status result not all zero")
   `HRLP_ASSERT(a_no_len_zero, (rsp_valid_ff && !rsp_user_ff[1]) |-> (rsp_data_ff == 32'd0),
      "length reported without header")
   `HRLP_ASSERT(a_match_range, (phase_ff == PH_MATCH) |->
      (match_ff != 4'd0 && match_ff < NAME_LEN), "name match index out of range")

endmodule

`default_nettype wire
